// ===== hdl/mf_pkg.sv =====
package mf_pkg;

   localparam int PIX_W         = 8;
   localparam int DIM_W         = 11;
   localparam int MIN_DIM       = 3;
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int HEIGHT_CAP    = 1024;
   localparam int WIDTH_RESET   = 640;
   localparam int HEIGHT_RESET  = 480;
   localparam int WIN_N         = 9;
   localparam int CSR_IDX_W     = 1;
   localparam int OUT_DEPTH     = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pix_type;

   // row-major 3x3 neighborhood, entry r*3+c
   typedef pix_type [WIN_N-1:0] win_type;

   typedef struct packed {
      logic emit;
      logic interior;
      logic last;
   } item_ctrl_type;

endpackage

// ===== hdl/mf_if.sv =====
interface mf_req_if;
   logic            valid;
   logic            ready;
   mf_pkg::pix_type pixel_in;
   logic            flush;

   modport source (output valid, pixel_in, flush, input ready);
   modport sink (input valid, pixel_in, flush, output ready);
endinterface

interface mf_rsp_if;
   logic            valid;
   logic            ready;
   mf_pkg::pix_type pixel_out;
   logic            frame_end;

   modport source (output valid, pixel_out, frame_end, input ready);
   modport sink (input valid, pixel_out, frame_end, output ready);
endinterface

// ===== hdl/median_filter_3x3.sv =====
// 3x3 median filter over a raster stream of 8-bit grey pixels.
// Throughput: one request per cycle while the output queue has credit, set by the
// row store doing one read and one write-back per cycle. A result leaves one row
// plus one pixel behind the stream, passing stages s1, s2, sa, sb and the queue.
// Reset: 640x480, counters and window cleared, output queue empty; the row store
// is not cleared and needs no clearing pass.
module median_filter_3x3 #(
   parameter int MAX_WIDTH = mf_pkg::MAX_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  mf_pkg::csr_index_type     csr_index,
   input  logic [mf_pkg::DIM_W-1:0]  csr_wdata,
   mf_req_if.sink                    req_ch,
   mf_rsp_if.source                  rsp_ch
);
   import mf_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   logic              credit_ok;
   logic              launch;
   logic [ADDR_W-1:0] launch_col;
   pix_type           launch_pix;
   item_ctrl_type     launch_ctrl;
   logic              win_valid;
   item_ctrl_type     win_ctrl;
   win_type           window;
   logic              med_valid;
   pix_type           med_pixel;
   logic              med_last;

   assign req_ch.ready = credit_ok;

   mf_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_ch.valid),
      .req_pixel    (req_ch.pixel_in),
      .req_flush    (req_ch.flush),
      .credit_ok    (credit_ok),
      .launch       (launch),
      .launch_col   (launch_col),
      .launch_pix   (launch_pix),
      .launch_ctrl  (launch_ctrl)
   );

   mf_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
      .clock       (clock),
      .reset       (reset),
      .launch      (launch),
      .launch_col  (launch_col),
      .launch_pix  (launch_pix),
      .launch_ctrl (launch_ctrl),
      .win_valid   (win_valid),
      .win_ctrl    (win_ctrl),
      .window      (window)
   );

   mf_median u_median (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_ctrl   (win_ctrl),
      .window    (window),
      .out_valid (med_valid),
      .out_pixel (med_pixel),
      .out_last  (med_last)
   );

   mf_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .reserve    (launch && launch_ctrl.emit),
      .push       (med_valid),
      .push_pixel (med_pixel),
      .push_last  (med_last),
      .rsp_ready  (rsp_ch.ready),
      .credit_ok  (credit_ok),
      .rsp_valid  (rsp_ch.valid),
      .rsp_pixel  (rsp_ch.pixel_out),
      .rsp_last   (rsp_ch.frame_end)
   );

endmodule

// ===== hdl/mf_ctrl.sv =====
module mf_ctrl #(
   parameter int MAX_WIDTH = mf_pkg::MAX_WIDTH_DEF,
   localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  mf_pkg::csr_index_type     csr_index,
   input  logic [mf_pkg::DIM_W-1:0]  csr_wdata,
   input  logic                      req_valid,
   input  mf_pkg::pix_type           req_pixel,
   input  logic                      req_flush,
   input  logic                      credit_ok,
   output logic                      launch,
   output logic [ADDR_W-1:0]         launch_col,
   output mf_pkg::pix_type           launch_pix,
   output mf_pkg::item_ctrl_type     launch_ctrl
);
   import mf_pkg::*;

   localparam int W_CAP = (MAX_WIDTH < (2**DIM_W - 1)) ? MAX_WIDTH : (2**DIM_W - 1);
   localparam int CMP_W = ((ADDR_W > DIM_W) ? ADDR_W : DIM_W) + 1;

   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   logic [ADDR_W-1:0] in_col_ff, in_col_in;
   logic [DIM_W-1:0]  in_row_ff, in_row_in;
   logic [ADDR_W-1:0] out_col_ff, out_col_in;
   logic [DIM_W-1:0]  out_row_ff, out_row_in;

   logic [DIM_W-1:0]  w_use, h_use;
   logic [CMP_W-1:0]  w_cmp, h_cmp;
   logic [CMP_W-1:0]  in_col_c, in_row_c, out_col_c, out_row_c;
   logic              accept, ignore, emit, interior, last;

   always_comb begin
      if (width_ff < DIM_W'(MIN_DIM)) begin
         w_use = DIM_W'(MIN_DIM);
      end else if (width_ff > DIM_W'(W_CAP)) begin
         w_use = DIM_W'(W_CAP);
      end else begin
         w_use = width_ff;
      end
      if (height_ff < DIM_W'(MIN_DIM)) begin
         h_use = DIM_W'(MIN_DIM);
      end else if (height_ff > DIM_W'(HEIGHT_CAP)) begin
         h_use = DIM_W'(HEIGHT_CAP);
      end else begin
         h_use = height_ff;
      end
   end

   assign w_cmp     = CMP_W'(w_use);
   assign h_cmp     = CMP_W'(h_use);
   assign in_col_c  = CMP_W'(in_col_ff);
   assign in_row_c  = CMP_W'(in_row_ff);
   assign out_col_c = CMP_W'(out_col_ff);
   assign out_row_c = CMP_W'(out_row_ff);

   // a flush before the last row is in does nothing
   assign accept = req_valid && credit_ok;
   assign ignore = req_flush && (in_row_c < h_cmp);
   assign launch = accept && !ignore;

   assign emit = (in_row_c >= CMP_W'(2)) ||
                 ((in_row_c == CMP_W'(1)) && (in_col_c >= CMP_W'(1)));
   assign interior = (out_row_c >= CMP_W'(1)) && (out_row_c + CMP_W'(2) <= h_cmp) &&
                     (out_col_c >= CMP_W'(1)) && (out_col_c + CMP_W'(2) <= w_cmp);
   assign last = (out_row_c + CMP_W'(1) >= h_cmp) && (out_col_c + CMP_W'(1) >= w_cmp);

   assign launch_col  = in_col_ff;
   assign launch_pix  = req_flush ? '0 : req_pixel;
   assign launch_ctrl = '{emit: emit, interior: interior, last: last};

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
         endcase
      end

      if (launch) begin
         if (in_col_c + CMP_W'(1) >= w_cmp) begin
            in_col_in = '0;
            in_row_in = in_row_ff + DIM_W'(1);
         end else begin
            in_col_in = in_col_ff + ADDR_W'(1);
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_c + CMP_W'(1) >= w_cmp) begin
               out_col_in = '0;
               out_row_in = out_row_ff + DIM_W'(1);
            end else begin
               out_col_in = out_col_ff + ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_W'(WIDTH_RESET);
         height_ff  <= DIM_W'(HEIGHT_RESET);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

// ===== hdl/mf_line_store.sv =====
module mf_line_store #(
   parameter int MAX_WIDTH = mf_pkg::MAX_WIDTH_DEF,
   localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   launch,
   input  logic [ADDR_W-1:0]      launch_col,
   input  mf_pkg::pix_type        launch_pix,
   input  mf_pkg::item_ctrl_type  launch_ctrl,
   output logic                   win_valid,
   output mf_pkg::item_ctrl_type  win_ctrl,
   output mf_pkg::win_type        window
);
   import mf_pkg::*;

   // entry = {two rows back, one row back}
   logic [2*PIX_W-1:0] store_mem [MAX_WIDTH];

   logic               s1_valid_ff;
   logic [ADDR_W-1:0]  s1_col_ff;
   pix_type            s1_pix_ff;
   item_ctrl_type      s1_ctrl_ff;
   logic [2*PIX_W-1:0] mem_rd_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic               fwd_ff;
   win_type            window_ff, window_in;
   logic               s2_valid_ff;
   item_ctrl_type      s2_ctrl_ff;

   logic [2*PIX_W-1:0] rd_data;
   pix_type            rd_up, rd_mid;
   logic [2*PIX_W-1:0] wr_data;
   logic               fwd;

   assign rd_data = fwd_ff ? fwd_data_ff : mem_rd_ff;
   assign rd_up   = rd_data[2*PIX_W-1:PIX_W];
   assign rd_mid  = rd_data[PIX_W-1:0];
   assign wr_data = {rd_mid, s1_pix_ff};

   // write-back of the previous request lands on the same edge as this read
   assign fwd = s1_valid_ff && (s1_col_ff == launch_col);

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         store_mem[s1_col_ff] <= wr_data;
      end
      if (launch) begin
         mem_rd_ff <= store_mem[launch_col];
      end
   end

   always_ff @(posedge clock) begin
      if (launch) begin
         fwd_ff      <= fwd;
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      window_in = window_ff;
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            window_in[r*3]   = window_ff[r*3+1];
            window_in[r*3+1] = window_ff[r*3+2];
         end
         window_in[2] = rd_up;
         window_in[5] = rd_mid;
         window_in[8] = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         window_ff   <= '0;
      end else begin
         s1_valid_ff <= launch;
         s2_valid_ff <= s1_valid_ff;
         window_ff   <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff  <= launch_col;
      s1_pix_ff  <= launch_pix;
      s1_ctrl_ff <= launch_ctrl;
      s2_ctrl_ff <= s1_ctrl_ff;
   end

   assign win_valid = s2_valid_ff;
   assign win_ctrl  = s2_ctrl_ff;
   assign window    = window_ff;

endmodule

// ===== hdl/mf_median.sv =====
module mf_median (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  mf_pkg::item_ctrl_type  in_ctrl,
   input  mf_pkg::win_type        window,
   output logic                   out_valid,
   output mf_pkg::pix_type        out_pixel,
   output logic                   out_last
);
   import mf_pkg::*;

   typedef pix_type [2:0]  trio_type;
   typedef trio_type [2:0] rows_type;

   // ascending: [0] smallest
   function automatic trio_type sort3(input pix_type a, input pix_type b, input pix_type c);
      pix_type x0, x1, x2, t;
      x0 = a;
      x1 = b;
      x2 = c;
      if (x0 > x1) begin
         t = x0; x0 = x1; x1 = t;
      end
      if (x1 > x2) begin
         t = x1; x1 = x2; x2 = t;
      end
      if (x0 > x1) begin
         t = x0; x0 = x1; x1 = t;
      end
      return {x2, x1, x0};
   endfunction

   logic     sa_valid_ff, sb_valid_ff;
   rows_type sa_rows_ff, sa_rows_in;
   pix_type  sa_center_ff, sb_center_ff;
   logic     sa_interior_ff, sb_interior_ff;
   logic     sa_last_ff, sb_last_ff;
   pix_type  sb_lo_ff, sb_mi_ff, sb_hi_ff;
   pix_type  lo_in, mi_in, hi_in;
   trio_type lows, mids, highs, fin;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sa_rows_in[r] = sort3(window[r*3], window[r*3+1], window[r*3+2]);
      end
   end

   // median of nine = med3(max of row minima, med of row medians, min of row maxima)
   always_comb begin
      lows  = sort3(sa_rows_ff[0][0], sa_rows_ff[1][0], sa_rows_ff[2][0]);
      mids  = sort3(sa_rows_ff[0][1], sa_rows_ff[1][1], sa_rows_ff[2][1]);
      highs = sort3(sa_rows_ff[0][2], sa_rows_ff[1][2], sa_rows_ff[2][2]);
      lo_in = lows[2];
      mi_in = mids[1];
      hi_in = highs[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
         sb_valid_ff <= 1'b0;
      end else begin
         sa_valid_ff <= in_valid && in_ctrl.emit;
         sb_valid_ff <= sa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sa_rows_ff     <= sa_rows_in;
      sa_center_ff   <= window[4];
      sa_interior_ff <= in_ctrl.interior;
      sa_last_ff     <= in_ctrl.last;
      sb_lo_ff       <= lo_in;
      sb_mi_ff       <= mi_in;
      sb_hi_ff       <= hi_in;
      sb_center_ff   <= sa_center_ff;
      sb_interior_ff <= sa_interior_ff;
      sb_last_ff     <= sa_last_ff;
   end

   assign fin       = sort3(sb_lo_ff, sb_mi_ff, sb_hi_ff);
   assign out_valid = sb_valid_ff;
   assign out_pixel = sb_interior_ff ? fin[1] : sb_center_ff;
   assign out_last  = sb_last_ff;

endmodule

// ===== hdl/mf_out_fifo.sv =====
module mf_out_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            reserve,
   input  logic            push,
   input  mf_pkg::pix_type push_pixel,
   input  logic            push_last,
   input  logic            rsp_ready,
   output logic            credit_ok,
   output logic            rsp_valid,
   output mf_pkg::pix_type rsp_pixel,
   output logic            rsp_last
);
   import mf_pkg::*;

   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   logic [PIX_W:0]     fifo_mem [OUT_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   level_ff, level_in;
   // results in flight plus results stored
   logic [CNT_W-1:0]   credit_ff, credit_in;
   logic               pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (level_ff != '0);
   assign {rsp_last, rsp_pixel} = fifo_mem[rd_ptr_ff];
   assign credit_ok = (credit_ff < CNT_W'(OUT_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      level_in  = level_ff + CNT_W'(push) - CNT_W'(pop);
      credit_in = credit_ff + CNT_W'(reserve) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= {push_last, push_pixel};
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mf_pkg::*;

   localparam int ITEM_BUDGET = 1200;
   localparam int IDLE_PCT    = 30;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_WAIT  = 16;
   localparam int QUIET_LIMIT = 4000;
   localparam int COL_W       = $clog2(MAX_WIDTH_DEF);

   typedef struct packed {
      pix_type pixel;
      logic    flush;
   } pixel_req_type;

   typedef struct packed {
      pix_type pixel;
      logic    frame_end;
   } filtered_type;

   logic              clock;
   logic              reset;
   logic              csr_write_en;
   csr_index_type     csr_index;
   logic [DIM_W-1:0]  csr_wdata;

   mf_req_if req_if ();
   mf_rsp_if rsp_if ();

   median_filter_3x3 dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_ch       (req_if),
      .rsp_ch       (rsp_if)
   );

   // predicted block state
   int unsigned      cfg_width;
   int unsigned      cfg_height;
   pix_type          prev2_row [MAX_WIDTH_DEF];
   pix_type          prev1_row [MAX_WIDTH_DEF];
   win_type          nbhd;
   int unsigned      col_in, row_in, col_out, row_out;

   pixel_req_type  pixel_stream_q [$];
   filtered_type   filtered_q [$];
   pixel_req_type  next_req;
   filtered_type   want;

   int          mismatches;
   int          stim_count;
   int          hold_left;
   bit          hold_done;
   bit          hold_trigger;
   bit          calm;
   int          quiet_cycles;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void filter_step(pix_type pix, logic is_flush);
      int unsigned      w, h;
      pix_type          above, middle;
      logic             produce, closing;
      int               lt, le;
      filtered_type     res;
      logic [COL_W-1:0] col_idx;
      w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
      h = clamp_dim(cfg_height, HEIGHT_CAP);
      if (is_flush) begin
         // flush is dropped while rows of the frame are still due
         if (row_in < h) return;
         pix = '0;
      end
      col_idx = COL_W'(col_in);
      above = prev2_row[col_idx];
      middle = prev1_row[col_idx];
      prev2_row[col_idx] = middle;
      prev1_row[col_idx] = pix;
      for (int r = 0; r < 3; r++) begin
         nbhd[r*3]   = nbhd[r*3+1];
         nbhd[r*3+1] = nbhd[r*3+2];
      end
      nbhd[2] = above;
      nbhd[5] = middle;
      nbhd[8] = pix;
      produce = (row_in >= 2) || (row_in == 1 && col_in >= 1);
      col_in++;
      if (col_in >= w) begin
         col_in = 0;
         row_in++;
      end
      if (!produce) return;
      res.pixel = nbhd[4];
      if (row_out >= 1 && row_out + 2 <= h && col_out >= 1 && col_out + 2 <= w) begin
         // median by rank: fewer than five below it, more than four at or below
         for (int i = 0; i < WIN_N; i++) begin
            lt = 0;
            le = 0;
            for (int j = 0; j < WIN_N; j++) begin
               if (nbhd[j] < nbhd[i]) lt++;
               if (nbhd[j] <= nbhd[i]) le++;
            end
            if (lt <= 4 && le > 4) res.pixel = nbhd[i];
         end
      end
      closing = (row_out + 1 >= h) && (col_out + 1 >= w);
      res.frame_end = closing;
      filtered_q.push_back(res);
      if (closing) begin
         col_in = 0;
         row_in = 0;
         col_out = 0;
         row_out = 0;
      end else begin
         col_out++;
         if (col_out >= w) begin
            col_out = 0;
            row_out++;
         end
      end
   endfunction

   function automatic void queue_request(pix_type p, logic f);
      pixel_stream_q.push_back('{pixel: p, flush: f});
   endfunction

   function automatic pix_type rand_pixel();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 6) return 8'h00;
      if (r < 12) return 8'hff;
      return pix_type'($urandom_range(255));
   endfunction

   // one frame in raster order: npix pixels, stray flushes inside, then the tail
   task automatic queue_frame(int unsigned w, int unsigned npix, bit with_tail);
      for (int unsigned i = 0; i < npix; i++) begin
         if ($urandom_range(99) < 4) queue_request(rand_pixel(), 1'b1);
         queue_request(rand_pixel(), 1'b0);
         stim_count++;
      end
      if (with_tail) begin
         // pixels in the tail act as flush
         for (int unsigned i = 0; i <= w; i++) begin
            queue_request(rand_pixel(), $urandom_range(99) < 70);
            stim_count++;
         end
         if ($urandom_range(99) < 20) queue_request(rand_pixel(), 1'b1);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_stream_q.size() != 0 || req_if.valid || filtered_q.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_size(int unsigned w, int unsigned h);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= DIM_W'(w);
      cfg_width = w & ((1 << DIM_W) - 1);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= DIM_W'(h);
      cfg_height = h & ((1 << DIM_W) - 1);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // feed pixels one at a time until the frame in progress closes
   task automatic finish_frame();
      while (col_in != 0 || row_in != 0) begin
         @(negedge clock);
         queue_request(rand_pixel(), 1'b0);
         do @(negedge clock);
         while (pixel_stream_q.size() != 0 || req_if.valid);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // request driver, predicts on every accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) filter_step(req_if.pixel_in, req_if.flush);
         if (!req_if.valid || req_if.ready) begin
            if (pixel_stream_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               next_req = pixel_stream_q.pop_front();
               req_if.valid <= 1'b1;
               req_if.pixel_in <= next_req.pixel;
               req_if.flush <= next_req.flush;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and ready generation
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (filtered_q.size() == 0) begin
               $error("unexpected result: pixel_out %0d frame_end %0b",
                      rsp_if.pixel_out, rsp_if.frame_end);
               mismatches++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_if.pixel_out !== want.pixel) begin
                  $error("pixel_out: expected %0d, got %0d", want.pixel, rsp_if.pixel_out);
                  mismatches++;
               end
               if (rsp_if.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_if.frame_end);
                  mismatches++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_trigger && !hold_done && rsp_if.valid) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned w, h, n;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.pixel_in = '0;
      req_if.flush = 1'b0;
      rsp_if.ready = 1'b0;
      cfg_width = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      nbhd = '0;
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
      foreach (prev2_row[i]) begin
         prev2_row[i] = '0;
         prev1_row[i] = '0;
      end
      mismatches = 0;
      stim_count = 0;
      hold_left = 0;
      hold_done = 1'b0;
      hold_trigger = 1'b0;
      calm = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // smallest frame: stray flush inside, pixel in the tail, extra flush after
      set_size(3, 3);
      @(negedge clock);
      queue_request(8'h00, 1'b0);
      queue_request(8'hff, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'hff, 1'b0);
      queue_request(8'h5a, 1'b1);
      queue_request(8'h80, 1'b0);
      queue_request(8'hff, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'hff, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'h00, 1'b1);
      queue_request(8'ha5, 1'b0);
      queue_request(8'hff, 1'b1);
      queue_request(8'h00, 1'b1);
      queue_request(8'h33, 1'b1);
      wait_drained();
      @(negedge clock);
      for (int i = 0; i < 8; i++) queue_request(pix_type'(1 << i), 1'b0);
      queue_request(8'hff, 1'b0);
      for (int i = 0; i < 4; i++) queue_request(8'hc3, 1'b0);
      wait_drained();

      // both sizes past their caps, widest row, no idling, long receiver hold
      set_size(2047, 2047);
      @(negedge clock);
      calm = 1'b1;
      hold_trigger = 1'b1;
      queue_frame(MAX_WIDTH_DEF, MAX_WIDTH_DEF + 40, 1'b0);
      wait_drained();
      calm = 1'b0;
      // shrink inside the wide frame and close it
      set_size(3, 3);
      finish_frame();
      wait_drained();

      while (stim_count < ITEM_BUDGET) begin
         if (col_in != 0 || row_in != 0) begin
            // resize inside a frame: any height, width only shrinks
            w = $urandom_range(clamp_dim(cfg_width, MAX_WIDTH_DEF), MIN_DIM);
            set_size(w, $urandom_range(12));
            finish_frame();
            wait_drained();
         end
         n = $urandom_range(99);
         if (n < 5) w = $urandom_range(2);
         else if (n < 80) w = $urandom_range(10, 3);
         else w = $urandom_range(24, 11);
         h = ($urandom_range(99) < 5) ? $urandom_range(2) : $urandom_range(8, 3);
         set_size(w, h);
         w = clamp_dim(w, MAX_WIDTH_DEF);
         h = clamp_dim(h, HEIGHT_CAP);
         @(negedge clock);
         n = $urandom_range(2, 1);
         for (int f = 0; f < n; f++) queue_frame(w, w * h, 1'b1);
         if ($urandom_range(99) < 20) queue_frame(w, $urandom_range(w * h - 1, 1), 1'b0);
         wait_drained();
      end
      finish_frame();
      wait_drained();
      repeat (20) @(posedge clock);

      if (mismatches == 0 && filtered_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
